[src/rbst_pkg.sv]
// ----------------------------------------------------------------------------
// rbst_pkg
// shared widths, types and register indexes of the ray/box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int CoordW   = 32;
	localparam int DiffW    = CoordW + 1;
	localparam int ProdW    = DiffW + CoordW;
	localparam int FracBits = 16;
	localparam int CfgIdxW  = 3;
	localparam int NumAxes  = 3;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [DiffW-1:0]  diff_t;
	typedef logic [CfgIdxW-1:0]       cfg_idx_t;

	localparam coord_t CoordMax = coord_t'({1'b0, {(CoordW-1){1'b1}}});
	localparam coord_t CoordMin = coord_t'({1'b1, {(CoordW-1){1'b0}}});

	localparam cfg_idx_t RegBoxMinX = cfg_idx_t'(0);
	localparam cfg_idx_t RegBoxMaxX = cfg_idx_t'(1);
	localparam cfg_idx_t RegBoxMinY = cfg_idx_t'(2);
	localparam cfg_idx_t RegBoxMaxY = cfg_idx_t'(3);
	localparam cfg_idx_t RegBoxMinZ = cfg_idx_t'(4);
	localparam cfg_idx_t RegBoxMaxZ = cfg_idx_t'(5);

	// stage enables handed to each distance lane
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} lane_ctrl_t;

endpackage

[src/rbst_cfg_if.sv]
// ----------------------------------------------------------------------------
// rbst_cfg_if
// register write channel: index and data per beat
// ----------------------------------------------------------------------------
interface rbst_cfg_if;
	logic               valid;
	logic               ready;
	rbst_pkg::cfg_idx_t index;
	rbst_pkg::coord_t   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rbst_ray_if.sv]
// ----------------------------------------------------------------------------
// rbst_ray_if
// ray channel: origin, inverse direction and parameter range per beat
// ----------------------------------------------------------------------------
interface rbst_ray_if;
	logic             valid;
	logic             ready;
	rbst_pkg::coord_t origin_x;
	rbst_pkg::coord_t origin_y;
	rbst_pkg::coord_t origin_z;
	rbst_pkg::coord_t inv_dir_x;
	rbst_pkg::coord_t inv_dir_y;
	rbst_pkg::coord_t inv_dir_z;
	rbst_pkg::coord_t t_near;
	rbst_pkg::coord_t t_far;

	modport source (output valid, output origin_x, output origin_y, output origin_z,
		output inv_dir_x, output inv_dir_y, output inv_dir_z, output t_near,
		output t_far, input ready);
	modport sink   (input valid, input origin_x, input origin_y, input origin_z,
		input inv_dir_x, input inv_dir_y, input inv_dir_z, input t_near,
		input t_far, output ready);
endinterface

[src/rbst_hit_if.sv]
// ----------------------------------------------------------------------------
// rbst_hit_if
// result channel: one hit flag per beat
// ----------------------------------------------------------------------------
interface rbst_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, output hit, input ready);
	modport sink   (input valid, input hit, output ready);
endinterface

[src/rbst_lane.sv]
// ----------------------------------------------------------------------------
// rbst_lane
// one slab distance: (bound - origin) * inv_dir in Q16.16, floor shift and
// saturation, two register stages
// ----------------------------------------------------------------------------
module rbst_lane (
	input  logic                clk,
	input  rbst_pkg::lane_ctrl_t ctrl,
	input  rbst_pkg::diff_t     diff,
	input  rbst_pkg::coord_t    inv_dir,
	output rbst_pkg::coord_t    t_slab
);

	localparam int ShW = rbst_pkg::ProdW - rbst_pkg::FracBits;

	logic signed [rbst_pkg::ProdW-1:0] prod_s2;
	logic signed [ShW-1:0]             shifted;
	logic                              fits;
	rbst_pkg::coord_t                  dist_sat;
	rbst_pkg::coord_t                  dist_s3;

	// full product, exact
	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			prod_s2 <= rbst_pkg::ProdW'(diff) * rbst_pkg::ProdW'(inv_dir);
		end
	end

	// dropping the fraction bits of a two's complement value rounds to minus infinity
	assign shifted = prod_s2[rbst_pkg::ProdW-1:rbst_pkg::FracBits];
	assign fits = (&shifted[ShW-1:rbst_pkg::CoordW-1])
		| ~(|shifted[ShW-1:rbst_pkg::CoordW-1]);

	always_comb begin
		if (fits) begin
			dist_sat = shifted[rbst_pkg::CoordW-1:0];
		end else if (prod_s2[rbst_pkg::ProdW-1]) begin
			dist_sat = rbst_pkg::CoordMin;
		end else begin
			dist_sat = rbst_pkg::CoordMax;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			dist_s3 <= dist_sat;
		end
	end

	assign t_slab = dist_s3;

endmodule

[src/ray_box_slab_test_core.sv]
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// ray versus axis-aligned box slab test, without back-pressure one ray per cycle
// ----------------------------------------------------------------------------
// The box is held in six signed Q16.16 registers written over cfg: index 0..5
// is min x, max x, min y, max y, min z, max z. Writes to other indexes are
// dropped. cfg is always ready; write it only while no ray is in flight.
// Each ray beat on ray yields exactly one beat on res, carrying hit.
// The stages are bound select and subtract, multiply, shift and saturate, x/y
// interval merge, z merge and range check. A new ray is taken every cycle until
// a stalled res fills the pipeline; the six 33x32 multipliers, one per slab
// distance, sit in the multiply stage. When res is stalled each stage holds
// while its successor is full; empty stages keep filling, so ray.ready drops
// only once all five stages are full. Reset empties the pipeline and loads
// the box with an empty box (min at the largest value, max at the smallest).
// ----------------------------------------------------------------------------
module ray_box_slab_test_core (
	input  logic    clk,
	input  logic    arst_n,
	rbst_cfg_if.sink cfg,
	rbst_ray_if.sink ray,
	rbst_hit_if.source res
);

	localparam int NAx = rbst_pkg::NumAxes;

	rbst_pkg::coord_t box_min_q [NAx];
	rbst_pkg::coord_t box_max_q [NAx];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	rbst_pkg::coord_t org [NAx];
	rbst_pkg::coord_t inv [NAx];

	rbst_pkg::diff_t  diff_lo_s1 [NAx];
	rbst_pkg::diff_t  diff_hi_s1 [NAx];
	rbst_pkg::coord_t inv_s1 [NAx];
	rbst_pkg::coord_t tn_s1, tf_s1, tn_s2, tf_s2, tn_s3, tf_s3, tn_s4, tf_s4;

	rbst_pkg::coord_t lo [NAx];
	rbst_pkg::coord_t hi [NAx];
	rbst_pkg::lane_ctrl_t lane_ctrl;

	rbst_pkg::coord_t tmin_s4, tmax_s4, lo_z_s4, hi_z_s4;
	logic             ok_s4;
	rbst_pkg::coord_t tmin_xy, tmax_xy, tmin_z, tmax_z;
	logic             ok_xy, ok_z;
	logic             hit_s5;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NAx; a++) begin
				box_min_q[a] <= rbst_pkg::CoordMax;
				box_max_q[a] <= rbst_pkg::CoordMin;
			end
		end else if (cfg.valid) begin
			case (cfg.index)
				rbst_pkg::RegBoxMinX: box_min_q[0] <= cfg.data;
				rbst_pkg::RegBoxMaxX: box_max_q[0] <= cfg.data;
				rbst_pkg::RegBoxMinY: box_min_q[1] <= cfg.data;
				rbst_pkg::RegBoxMaxY: box_max_q[1] <= cfg.data;
				rbst_pkg::RegBoxMinZ: box_min_q[2] <= cfg.data;
				rbst_pkg::RegBoxMaxZ: box_max_q[2] <= cfg.data;
				default: ;
			endcase
		end
	end

	// per-stage ready so bubbles collapse under a stalled receiver
	assign rdy5      = !v_s5 || res.ready;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign ray.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= ray.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1: sign of inverse direction picks the near bound
	assign org[0] = ray.origin_x;
	assign org[1] = ray.origin_y;
	assign org[2] = ray.origin_z;
	assign inv[0] = ray.inv_dir_x;
	assign inv[1] = ray.inv_dir_y;
	assign inv[2] = ray.inv_dir_z;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int a = 0; a < NAx; a++) begin
				if (inv[a][rbst_pkg::CoordW-1]) begin
					diff_lo_s1[a] <= rbst_pkg::DiffW'(box_max_q[a]) - rbst_pkg::DiffW'(org[a]);
					diff_hi_s1[a] <= rbst_pkg::DiffW'(box_min_q[a]) - rbst_pkg::DiffW'(org[a]);
				end else begin
					diff_lo_s1[a] <= rbst_pkg::DiffW'(box_min_q[a]) - rbst_pkg::DiffW'(org[a]);
					diff_hi_s1[a] <= rbst_pkg::DiffW'(box_max_q[a]) - rbst_pkg::DiffW'(org[a]);
				end
				inv_s1[a] <= inv[a];
			end
			tn_s1 <= ray.t_near;
			tf_s1 <= ray.t_far;
		end
	end

	// stages 2 and 3: slab distances
	assign lane_ctrl.en_s2 = rdy2;
	assign lane_ctrl.en_s3 = rdy3;

	for (genvar a = 0; a < NAx; a++) begin : g_axis
		rbst_lane u_lane_lo (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.diff    (diff_lo_s1[a]),
			.inv_dir (inv_s1[a]),
			.t_slab  (lo[a])
		);
		rbst_lane u_lane_hi (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.diff    (diff_hi_s1[a]),
			.inv_dir (inv_s1[a]),
			.t_slab  (hi[a])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			tn_s2 <= tn_s1;
			tf_s2 <= tf_s1;
		end
		if (rdy3) begin
			tn_s3 <= tn_s2;
			tf_s3 <= tf_s2;
		end
	end

	// stage 4: x against y, strict reject then narrow
	always_comb begin
		ok_xy   = !((lo[0] > hi[1]) || (lo[1] > hi[0]));
		tmin_xy = (lo[1] > lo[0]) ? lo[1] : lo[0];
		tmax_xy = (hi[1] < hi[0]) ? hi[1] : hi[0];
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			ok_s4   <= ok_xy;
			tmin_s4 <= tmin_xy;
			tmax_s4 <= tmax_xy;
			lo_z_s4 <= lo[2];
			hi_z_s4 <= hi[2];
			tn_s4   <= tn_s3;
			tf_s4   <= tf_s3;
		end
	end

	// stage 5: merge z, then check against the parameter range
	always_comb begin
		ok_z   = !((tmin_s4 > hi_z_s4) || (lo_z_s4 > tmax_s4));
		tmin_z = (lo_z_s4 > tmin_s4) ? lo_z_s4 : tmin_s4;
		tmax_z = (hi_z_s4 < tmax_s4) ? hi_z_s4 : tmax_s4;
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			hit_s5 <= ok_s4 && ok_z && (tmin_z < tf_s4) && (tmax_z > tn_s4);
		end
	end

	assign res.valid = v_s5;
	assign res.hit   = hit_s5;

endmodule

[sim/ray_box_slab_test_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_core_test
// self-checking bench for the ray/box slab test core
// ----------------------------------------------------------------------------
// Rays are pushed through the ray channel while the box registers are set up
// over the cfg channel between phases. Every accepted ray is scored by an
// in-bench Q16.16 slab computation against the current box, and each beat on
// the result channel is checked in order against those predicted hit flags.
// Directed rays cover the reset box, each register, zero directions,
// saturating products, the strict range compares and an inverted box. Random
// phases then mix aimed, scattered and raw rays under varied stall patterns.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core_test;

	typedef rbst_pkg::coord_t coord_t;

	localparam int     PipeDepth = 5;
	localparam int     PhaseRays = 270;
	localparam int     NumPhases = 7;
	localparam int     HoldOff   = 40;
	localparam int     NAx       = rbst_pkg::NumAxes;
	localparam coord_t QOne      = coord_t'(1 << rbst_pkg::FracBits);
	localparam coord_t CMax      = rbst_pkg::CoordMax;
	localparam coord_t CMin      = rbst_pkg::CoordMin;

	localparam logic signed [rbst_pkg::ProdW-1:0] DistMax = rbst_pkg::CoordMax;
	localparam logic signed [rbst_pkg::ProdW-1:0] DistMin = rbst_pkg::CoordMin;

	typedef struct packed {
		coord_t org_x, org_y, org_z;
		coord_t inv_x, inv_y, inv_z;
		coord_t t_near, t_far;
	} ray_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_PATTERN} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	rbst_cfg_if cfg_bus ();
	rbst_ray_if ray_bus ();
	rbst_hit_if res_bus ();

	ray_box_slab_test_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.ray    (ray_bus),
		.res    (res_bus)
	);

	coord_t     box_lo [NAx];
	coord_t     box_hi [NAx];
	bit         pending_hits [$];
	bit         expected_hit;
	int         mismatches;
	int         ray_count;
	int         hit_count;
	int         miss_count;
	int         box_count;
	int         hold_left;
	int         sink_tick;
	sink_mode_t sink_mode;

	// ------------------------------------------------------------------
	// slab arithmetic
	// ------------------------------------------------------------------

	// (bound - origin) * inv, floor shift by the fraction, saturate to 32 bits
	function automatic coord_t slab_distance(input coord_t bound, input coord_t origin,
		input coord_t inv);
		logic signed [rbst_pkg::ProdW-1:0] span;
		logic signed [rbst_pkg::ProdW-1:0] scaled;
		span   = bound - origin;
		scaled = (span * inv) >>> rbst_pkg::FracBits;
		if (scaled > DistMax)
			return CMax;
		if (scaled < DistMin)
			return CMin;
		return coord_t'(scaled);
	endfunction

	function automatic bit predict_hit(input ray_t r);
		coord_t org [NAx];
		coord_t inv [NAx];
		coord_t t_in [NAx];
		coord_t t_out [NAx];
		coord_t tmin;
		coord_t tmax;
		bit     alive;
		org = '{r.org_x, r.org_y, r.org_z};
		inv = '{r.inv_x, r.inv_y, r.inv_z};
		for (int a = 0; a < NAx; a++) begin
			// negative direction enters through the max face
			if (inv[a] < 0) begin
				t_in[a]  = slab_distance(box_hi[a], org[a], inv[a]);
				t_out[a] = slab_distance(box_lo[a], org[a], inv[a]);
			end else begin
				t_in[a]  = slab_distance(box_lo[a], org[a], inv[a]);
				t_out[a] = slab_distance(box_hi[a], org[a], inv[a]);
			end
		end
		tmin  = t_in[0];
		tmax  = t_out[0];
		alive = 1'b1;
		for (int a = 1; a < NAx && alive; a++) begin
			if (tmin > t_out[a] || t_in[a] > tmax) begin
				alive = 1'b0;
			end else begin
				if (t_in[a] > tmin)
					tmin = t_in[a];
				if (t_out[a] < tmax)
					tmax = t_out[a];
			end
		end
		return alive && (tmin < r.t_far) && (tmax > r.t_near);
	endfunction

	// ------------------------------------------------------------------
	// stimulus values
	// ------------------------------------------------------------------

	function automatic coord_t q16(input int v);
		return coord_t'(v * QOne);
	endfunction

	// uniform in [-2^bits, 2^bits)
	function automatic coord_t rand_signed(input int bits);
		int unsigned span;
		span = 1 << bits;
		return coord_t'(int'($urandom_range(0, 2 * span - 1)) - int'(span));
	endfunction

	function automatic coord_t rand_edge();
		case ($urandom_range(0, 5))
			0: return CMin;
			1: return CMax;
			2: return coord_t'(0);
			3: return coord_t'(-1);
			4: return coord_t'(1);
			default: return QOne;
		endcase
	endfunction

	function automatic coord_t rand_raw();
		if ($urandom_range(0, 3) == 0)
			return rand_edge();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t rand_inv();
		int unsigned k;
		k = $urandom_range(0, 15);
		if (k < 2)
			return coord_t'(0);
		if (k == 2)
			return rand_edge();
		if (k == 3)
			return coord_t'($urandom);
		return rand_signed(18);
	endfunction

	// aimed rays pass through a point of the box at t of about one
	function automatic ray_t gen_ray();
		ray_t   r;
		coord_t org [NAx];
		coord_t inv [NAx];
		coord_t tgt;
		longint d;
		longint q;
		int unsigned kind;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			for (int a = 0; a < NAx; a++) begin
				if (box_lo[a] <= box_hi[a])
					tgt = coord_t'(longint'(box_lo[a]) + longint'($urandom) %
						(longint'(box_hi[a]) - longint'(box_lo[a]) + 1));
				else
					tgt = rand_signed(22);
				org[a] = tgt + rand_signed(22);
				d = longint'(tgt) - longint'(org[a]);
				if (d == 0 || $urandom_range(0, 15) == 0) begin
					inv[a] = coord_t'(0);
				end else begin
					q = (longint'(1) <<< 32) / d;
					if (q > longint'(CMax))
						q = longint'(CMax);
					if (q < longint'(CMin))
						q = longint'(CMin);
					inv[a] = coord_t'(q);
				end
			end
			r.t_near = rand_signed(17);
			if ($urandom_range(0, 3) == 0)
				r.t_far = rand_signed(18);
			else
				r.t_far = coord_t'(QOne / 2 + int'($urandom_range(0, 4 * QOne)));
		end else if (kind < 8) begin
			for (int a = 0; a < NAx; a++) begin
				org[a] = rand_signed(25);
				inv[a] = rand_inv();
			end
			r.t_near = rand_signed(18);
			r.t_far  = rand_signed(24);
		end else begin
			for (int a = 0; a < NAx; a++) begin
				org[a] = rand_raw();
				inv[a] = rand_raw();
			end
			r.t_near = rand_raw();
			r.t_far  = rand_raw();
		end
		r.org_x = org[0];
		r.org_y = org[1];
		r.org_z = org[2];
		r.inv_x = inv[0];
		r.inv_y = inv[1];
		r.inv_z = inv[2];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// channel drivers, all entered and left at a falling edge
	// ------------------------------------------------------------------

	task automatic write_reg(input rbst_pkg::cfg_idx_t idx, input coord_t val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		case (idx)
			rbst_pkg::RegBoxMinX: box_lo[0] = val;
			rbst_pkg::RegBoxMaxX: box_hi[0] = val;
			rbst_pkg::RegBoxMinY: box_lo[1] = val;
			rbst_pkg::RegBoxMaxY: box_hi[1] = val;
			rbst_pkg::RegBoxMinZ: box_lo[2] = val;
			rbst_pkg::RegBoxMaxZ: box_hi[2] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// leaves valid high so that the next beat can follow without a gap
	task automatic send_ray(input ray_t r);
		ray_bus.valid     <= 1'b1;
		ray_bus.origin_x  <= r.org_x;
		ray_bus.origin_y  <= r.org_y;
		ray_bus.origin_z  <= r.org_z;
		ray_bus.inv_dir_x <= r.inv_x;
		ray_bus.inv_dir_y <= r.inv_y;
		ray_bus.inv_dir_z <= r.inv_z;
		ray_bus.t_near    <= r.t_near;
		ray_bus.t_far     <= r.t_far;
		do @(posedge clk); while (ray_bus.ready !== 1'b1);
		pending_hits.push_back(predict_hit(r));
		ray_count++;
		@(negedge clk);
	endtask

	task automatic idle_ray(input int cycles);
		ray_bus.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic wait_drain();
		ray_bus.valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(negedge clk);
		repeat (PipeDepth + 2) @(negedge clk);
	endtask

	task automatic program_box(input coord_t lo_b [NAx], input coord_t hi_b [NAx]);
		wait_drain();
		write_reg(rbst_pkg::RegBoxMinX, lo_b[0]);
		write_reg(rbst_pkg::RegBoxMaxX, hi_b[0]);
		write_reg(rbst_pkg::RegBoxMinY, lo_b[1]);
		write_reg(rbst_pkg::RegBoxMaxY, hi_b[1]);
		write_reg(rbst_pkg::RegBoxMinZ, lo_b[2]);
		write_reg(rbst_pkg::RegBoxMaxZ, hi_b[2]);
		box_count++;
	endtask

	// ------------------------------------------------------------------
	// result side: stall pattern and in-order check
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			res_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			case (sink_mode)
				SINK_OPEN:   res_bus.ready <= 1'b1;
				SINK_RANDOM: res_bus.ready <= ($urandom_range(0, 3) != 0);
				default:     res_bus.ready <= ((sink_tick % 7) >= 2);
			endcase
		end
		sink_tick++;
	end

	always @(posedge clk) begin
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (pending_hits.size() == 0) begin
				$display("%0t: result beat with no ray pending, expected none, actual hit=%b",
					$time, res_bus.hit);
				mismatches++;
			end else begin
				expected_hit = pending_hits.pop_front();
				if (res_bus.hit !== expected_hit) begin
					$display("%0t: hit mismatch, expected %b, actual %b", $time,
						expected_hit, res_bus.hit);
					mismatches++;
				end
				if (expected_hit)
					hit_count++;
				else
					miss_count++;
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// registers still hold the empty box from reset
	task automatic test_reset_box();
		send_ray(ray_t'{q16(0), q16(0), q16(0), QOne, QOne, QOne, q16(-1), q16(1)});
		send_ray(ray_t'{q16(0), q16(0), q16(0), 0, 0, 0, CMin, CMax});
	endtask

	// box of different size per axis, so each bound shows up in some result
	task automatic test_register_map();
		coord_t lo_b [NAx];
		coord_t hi_b [NAx];
		lo_b = '{q16(-1), q16(-2), q16(-3)};
		hi_b = '{q16(1), q16(2), q16(3)};
		program_box(lo_b, hi_b);
		// writes beyond the last register must leave the box alone
		for (int i = rbst_pkg::RegBoxMaxZ + 1; i < (1 << rbst_pkg::CfgIdxW); i++)
			write_reg(rbst_pkg::cfg_idx_t'(i), q16(0));
		send_ray(ray_t'{q16(-5), q16(-5), q16(-5), QOne, QOne, QOne, q16(0), q16(10)});
		send_ray(ray_t'{q16(-5), q16(0), q16(0), QOne, QOne, QOne, q16(0), q16(10)});
		send_ray(ray_t'{q16(0), q16(0), q16(-5), QOne, QOne, QOne, q16(-10), q16(10)});
		send_ray(ray_t'{-5 * QOne / 2, -5 * QOne / 2, -5 * QOne / 2, QOne, QOne, QOne,
			q16(0), q16(10)});
		send_ray(ray_t'{q16(5), q16(5), q16(5), -QOne, -QOne, -QOne, q16(0), q16(10)});
	endtask

	// a zero inverse direction pins that axis to the interval [0, 0]
	task automatic test_zero_direction();
		send_ray(ray_t'{q16(0), q16(0), q16(0), 0, QOne, QOne, q16(-1), q16(1)});
		send_ray(ray_t'{q16(0), q16(0), q16(0), 0, QOne, QOne, q16(0), q16(1)});
		send_ray(ray_t'{q16(5), q16(0), q16(0), 0, QOne, QOne, q16(-1), q16(1)});
		send_ray(ray_t'{q16(-5), q16(0), q16(0), QOne, 0, 0, q16(-10), q16(10)});
	endtask

	// full-range box and extreme operands drive the products into saturation
	task automatic test_saturation();
		coord_t lo_b [NAx];
		coord_t hi_b [NAx];
		lo_b = '{CMin, CMin, CMin};
		hi_b = '{CMax, CMax, CMax};
		program_box(lo_b, hi_b);
		send_ray(ray_t'{CMin, CMin, CMin, CMax, CMax, CMax, CMin, CMax});
		send_ray(ray_t'{CMax, CMax, CMax, CMin, CMin, CMin, CMin, CMax});
		send_ray(ray_t'{q16(0), q16(0), q16(0), -1, -1, -1, q16(-1), q16(1)});
		send_ray(ray_t'{CMin, CMin, CMin, 1, 1, 1, CMax, CMin});
	endtask

	// interval is [2, 4]; touching either end of the range is a miss
	task automatic test_range_edges();
		coord_t lo_b [NAx];
		coord_t hi_b [NAx];
		lo_b = '{q16(-1), q16(-1), q16(-1)};
		hi_b = '{q16(1), q16(1), q16(1)};
		program_box(lo_b, hi_b);
		send_ray(ray_t'{q16(-3), q16(-3), q16(-3), QOne, QOne, QOne, q16(0), q16(2)});
		send_ray(ray_t'{q16(-3), q16(-3), q16(-3), QOne, QOne, QOne, q16(0), q16(2) + 1});
		send_ray(ray_t'{q16(-3), q16(-3), q16(-3), QOne, QOne, QOne, q16(4), q16(10)});
		send_ray(ray_t'{q16(-3), q16(-3), q16(-3), QOne, QOne, QOne, q16(4) - 1, q16(10)});
	endtask

	task automatic test_inverted_box();
		coord_t lo_b [NAx];
		coord_t hi_b [NAx];
		lo_b = '{q16(1), q16(1), q16(1)};
		hi_b = '{q16(-1), q16(-1), q16(-1)};
		program_box(lo_b, hi_b);
		send_ray(ray_t'{q16(-3), q16(-3), q16(-3), QOne, QOne, QOne, q16(-10), q16(10)});
		send_ray(ray_t'{q16(0), q16(0), q16(0), -QOne, -QOne, -QOne, q16(-10), q16(10)});
	endtask

	// result side held off while rays keep coming, so the pipe fills and
	// ray.ready drops; then the sender waits for every result
	task automatic test_backpressure();
		sink_mode = SINK_OPEN;
		hold_left = HoldOff;
		repeat (30) send_ray(gen_ray());
		wait_drain();
		sink_mode = SINK_RANDOM;
	endtask

	task automatic test_random_phases();
		coord_t      lo_b [NAx];
		coord_t      hi_b [NAx];
		coord_t      centre;
		int unsigned half;
		int          burst;
		bit          gapless;
		for (int p = 0; p < NumPhases; p++) begin
			for (int a = 0; a < NAx; a++) begin
				centre = rand_signed(22);
				half   = $urandom_range(0, 1 << 21);
				case (p)
					1: begin
						lo_b[a] = CMin;
						hi_b[a] = CMax;
					end
					2: begin
						lo_b[a] = CMax;
						hi_b[a] = CMin;
					end
					4: begin
						lo_b[a] = centre + coord_t'(half);
						hi_b[a] = centre - coord_t'(half);
					end
					default: begin
						lo_b[a] = centre - coord_t'(half);
						hi_b[a] = centre + coord_t'(half);
					end
				endcase
			end
			program_box(lo_b, hi_b);
			sink_mode = sink_mode_t'(p % 3);
			gapless   = (p % 3 == 0);
			burst     = $urandom_range(1, 24);
			for (int n = 0; n < PhaseRays; n++) begin
				send_ray(gen_ray());
				if (!gapless) begin
					burst--;
					if (burst == 0) begin
						idle_ray($urandom_range(1, 8));
						burst = $urandom_range(1, 24);
					end
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n            = 1'b0;
		cfg_bus.valid     = 1'b0;
		cfg_bus.index     = '0;
		cfg_bus.data      = '0;
		ray_bus.valid     = 1'b0;
		ray_bus.origin_x  = '0;
		ray_bus.origin_y  = '0;
		ray_bus.origin_z  = '0;
		ray_bus.inv_dir_x = '0;
		ray_bus.inv_dir_y = '0;
		ray_bus.inv_dir_z = '0;
		ray_bus.t_near    = '0;
		ray_bus.t_far     = '0;
		res_bus.ready     = 1'b0;
		sink_mode         = SINK_RANDOM;
		hold_left         = 0;
		sink_tick         = 0;
		mismatches        = 0;
		ray_count         = 0;
		hit_count         = 0;
		miss_count        = 0;
		box_count         = 0;
		for (int a = 0; a < NAx; a++) begin
			box_lo[a] = CMax;
			box_hi[a] = CMin;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_box();
		test_register_map();
		test_zero_direction();
		test_saturation();
		test_range_edges();
		test_inverted_box();
		test_backpressure();
		test_random_phases();
		wait_drain();

		$display("%0d rays checked over %0d box settings: %0d hits, %0d misses",
			ray_count, box_count, hit_count, miss_count);
		$display("included a held-off result side with the ray input stalled, %0d mismatches",
			mismatches);
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit, far above the slowest legal run
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
src/rbst_pkg.sv
src/rbst_cfg_if.sv
src/rbst_ray_if.sv
src/rbst_hit_if.sv
src/rbst_lane.sv
src/ray_box_slab_test_core.sv
sim/ray_box_slab_test_core_test.sv
